### sv/xmov_pkg.sv
`default_nettype none

package xmov_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned NUM_REGS   = 8;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [2:0]            reg_idx_type;
   typedef logic [1:0]            size_type;
   typedef logic [2:0]            op_type;
   typedef logic [1:0]            kind_type;
   typedef logic [1:0]            pend_type;

   localparam op_type OP_RM_R     = 3'd0;
   localparam op_type OP_R_RM     = 3'd1;
   localparam op_type OP_ACC_MOFF = 3'd2;
   localparam op_type OP_MOFF_ACC = 3'd3;
   localparam op_type OP_R_IMM    = 3'd4;
   localparam op_type OP_RM_IMM   = 3'd5;
   localparam op_type OP_MOVSB    = 3'd6;
   localparam op_type OP_LOAD_RET = 3'd7;

   localparam size_type SZ_BYTE    = 2'd0;
   localparam size_type SZ_WORD    = 2'd1;
   localparam size_type SZ_DWORD   = 2'd2;
   localparam size_type SZ_ILLEGAL = 2'd3;

   localparam kind_type KIND_DONE  = 2'd0;
   localparam kind_type KIND_READ  = 2'd1;
   localparam kind_type KIND_WRITE = 2'd2;
   localparam kind_type KIND_ERROR = 2'd3;

   localparam pend_type PEND_NONE  = 2'd0;
   localparam pend_type PEND_LOAD  = 2'd1;
   localparam pend_type PEND_MOVSB = 2'd2;

   localparam reg_idx_type REG_EAX = 3'd0;
   localparam reg_idx_type REG_ECX = 3'd1;
   localparam reg_idx_type REG_ESI = 3'd6;
   localparam reg_idx_type REG_EDI = 3'd7;
   localparam logic [3:0]  NO_REG  = 4'd8;

   // Full register behind a view: byte views 4 to 7 live in registers 0 to 3.
   function automatic reg_idx_type view_reg(input size_type sz, input reg_idx_type idx);
      view_reg = (sz == SZ_BYTE) ? {1'b0, idx[1:0]} : idx;
   endfunction

   function automatic word_type view_get(input size_type sz, input reg_idx_type idx,
                                         input word_type full);
      if (sz == SZ_BYTE) begin
         view_get = idx[2] ? {24'd0, full[15:8]} : {24'd0, full[7:0]};
      end else if (sz == SZ_WORD) begin
         view_get = {16'd0, full[15:0]};
      end else begin
         view_get = full;
      end
   endfunction

   function automatic word_type view_put(input size_type sz, input reg_idx_type idx,
                                         input word_type full, input word_type v);
      if (sz == SZ_BYTE) begin
         view_put = idx[2] ? {full[31:16], v[7:0], full[7:0]} : {full[31:8], v[7:0]};
      end else if (sz == SZ_WORD) begin
         view_put = {full[31:16], v[15:0]};
      end else begin
         view_put = v;
      end
   endfunction

   function automatic word_type size_mask(input size_type sz);
      if (sz == SZ_BYTE) begin
         size_mask = 32'h0000_00FF;
      end else if (sz == SZ_WORD) begin
         size_mask = 32'h0000_FFFF;
      end else begin
         size_mask = 32'hFFFF_FFFF;
      end
   endfunction

endpackage

`default_nettype wire

### sv/x86_mov_execute_unit.sv
`default_nettype none

// Executes x86 MOV forms and MOVSB against eight 32-bit registers. Every
// transaction, instruction or load return, yields exactly one response: done,
// a memory read or write request, or an error. One transaction is accepted per
// clock while responses are taken. The input register (which also captures the
// two register-file operands) holds it until the response register is free or
// being read, and the response register is then loaded. It decouples the sides,
// so an empty input register can still take a new transaction while a response
// waits. Memory addresses are masked to ADDR_WIDTH bits.
module x86_mov_execute_unit
   import xmov_pkg::*;
#(
   parameter int unsigned ADDR_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [1:0]  req_size,
   input  wire logic        req_mod_is_reg,
   input  wire logic [2:0]  req_reg_field,
   input  wire logic [2:0]  req_rm_field,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_immediate,
   input  wire logic        req_rep_prefix,
   input  wire logic        req_direction_flag,
   input  wire logic [31:0] req_load_data,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_mem_address,
   output logic [31:0]      rsp_mem_data,
   output logic [1:0]       rsp_mem_size,
   output logic [3:0]       rsp_written_reg,
   output logic [31:0]      rsp_written_value,
   output logic             rsp_repeat_res
);

   word_type rf_ff [NUM_REGS];
   word_type rf_in [NUM_REGS];

   pend_type    pend_kind_ff, pend_kind_in;
   reg_idx_type pend_dest_ff, pend_dest_in;
   size_type    pend_size_ff, pend_size_in;

   logic        x_valid_ff;
   op_type      x_op_ff;
   size_type    x_size_ff;
   logic        x_mod_is_reg_ff;
   reg_idx_type x_reg_field_ff;
   reg_idx_type x_rm_field_ff;
   word_type    x_address_ff;
   word_type    x_immediate_ff;
   logic        x_rep_ff;
   logic        x_df_ff;
   word_type    x_load_data_ff;
   word_type    x_src_ff, x_src_in;
   word_type    x_dst_ff, x_dst_in;

   logic        rsp_valid_ff;
   kind_type    rsp_kind_ff, rsp_kind_in;
   word_type    rsp_addr_ff, rsp_addr_in;
   word_type    rsp_data_ff, rsp_data_in;
   size_type    rsp_size_ff, rsp_size_in;
   logic [3:0]  rsp_wreg_ff, rsp_wreg_in;
   word_type    rsp_wval_ff, rsp_wval_in;
   logic        rsp_rpt_ff, rsp_rpt_in;

   logic        advance;
   logic        accept;
   reg_idx_type src_field;
   reg_idx_type dst_field;
   size_type    dst_size;

   size_type    c_size;
   reg_idx_type c_idx;
   reg_idx_type c_reg;
   word_type    c_val;
   word_type    c_new;
   logic        c_write;
   word_type    step;
   word_type    ecx_dec;

   assign advance   = x_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !x_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // Operand capture reads the register file as it will be after the
   // transaction now completing, so back-to-back dependencies see new values.
   always_comb begin
      src_field = (req_op == OP_R_RM) ? req_rm_field : req_reg_field;
      dst_size  = req_size;
      unique case (req_op) inside
         OP_RM_R, OP_RM_IMM: dst_field = req_rm_field;
         OP_LOAD_RET: begin
            dst_field = pend_dest_in;
            dst_size  = pend_size_in;
         end
         default: dst_field = req_reg_field;
      endcase
      x_src_in = rf_in[view_reg(req_size, src_field)];
      x_dst_in = rf_in[view_reg(dst_size, dst_field)];
   end

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         rf_in[i] = rf_ff[i];
      end
      pend_kind_in = pend_kind_ff;
      pend_dest_in = pend_dest_ff;
      pend_size_in = pend_size_ff;

      rsp_kind_in = KIND_DONE;
      rsp_addr_in = '0;
      rsp_data_in = '0;
      rsp_size_in = SZ_BYTE;
      rsp_wreg_in = NO_REG;
      rsp_wval_in = '0;
      rsp_rpt_in  = 1'b0;

      c_size  = x_size_ff;
      c_idx   = x_reg_field_ff;
      c_val   = '0;
      c_write = 1'b0;
      step    = x_df_ff ? 32'hFFFF_FFFF : 32'd1;
      ecx_dec = rf_ff[REG_ECX] - 32'd1;

      if (advance) begin
         if (x_op_ff == OP_LOAD_RET) begin
            pend_kind_in = PEND_NONE;
            if (pend_kind_ff == PEND_LOAD) begin
               c_size  = pend_size_ff;
               c_idx   = pend_dest_ff;
               c_val   = x_load_data_ff & size_mask(pend_size_ff);
               c_write = 1'b1;
            end else if (pend_kind_ff == PEND_MOVSB) begin
               step             = pend_dest_ff[0] ? 32'hFFFF_FFFF : 32'd1;
               rsp_kind_in      = KIND_WRITE;
               rsp_addr_in      = 32'(rf_ff[REG_EDI][ADDR_WIDTH-1:0]);
               rsp_data_in      = {24'd0, x_load_data_ff[7:0]};
               rf_in[REG_EDI]   = rf_ff[REG_EDI] + step;
               rf_in[REG_ESI]   = rf_ff[REG_ESI] + step;
               rsp_wreg_in      = {1'b0, REG_EDI};
               rsp_wval_in      = rf_ff[REG_EDI] + step;
               rsp_rpt_in       = pend_dest_ff[1];
            end else begin
               rsp_kind_in = KIND_ERROR;
            end
         end else if (x_size_ff == SZ_ILLEGAL ||
                      (x_op_ff == OP_MOVSB && x_size_ff == SZ_WORD)) begin
            rsp_kind_in = KIND_ERROR;
         end else begin
            pend_kind_in = PEND_NONE;
            unique case (x_op_ff)
               OP_RM_R: begin
                  if (x_mod_is_reg_ff) begin
                     c_idx   = x_rm_field_ff;
                     c_val   = view_get(x_size_ff, x_reg_field_ff, x_src_ff);
                     c_write = 1'b1;
                  end else begin
                     rsp_kind_in = KIND_WRITE;
                     rsp_addr_in = 32'(x_address_ff[ADDR_WIDTH-1:0]);
                     rsp_data_in = view_get(x_size_ff, x_reg_field_ff, x_src_ff);
                     rsp_size_in = x_size_ff;
                  end
               end
               OP_R_RM: begin
                  if (x_mod_is_reg_ff) begin
                     c_idx   = x_reg_field_ff;
                     c_val   = view_get(x_size_ff, x_rm_field_ff, x_src_ff);
                     c_write = 1'b1;
                  end else begin
                     rsp_kind_in  = KIND_READ;
                     rsp_addr_in  = 32'(x_address_ff[ADDR_WIDTH-1:0]);
                     rsp_size_in  = x_size_ff;
                     pend_kind_in = PEND_LOAD;
                     pend_dest_in = x_reg_field_ff;
                     pend_size_in = x_size_ff;
                  end
               end
               OP_ACC_MOFF: begin
                  rsp_kind_in  = KIND_READ;
                  rsp_addr_in  = 32'(x_address_ff[ADDR_WIDTH-1:0]);
                  rsp_size_in  = x_size_ff;
                  pend_kind_in = PEND_LOAD;
                  pend_dest_in = REG_EAX;
                  pend_size_in = x_size_ff;
               end
               OP_MOFF_ACC: begin
                  rsp_kind_in = KIND_WRITE;
                  rsp_addr_in = 32'(x_address_ff[ADDR_WIDTH-1:0]);
                  rsp_data_in = view_get(x_size_ff, REG_EAX, rf_ff[REG_EAX]);
                  rsp_size_in = x_size_ff;
               end
               OP_R_IMM: begin
                  c_idx   = x_reg_field_ff;
                  c_val   = x_immediate_ff & size_mask(x_size_ff);
                  c_write = 1'b1;
               end
               OP_RM_IMM: begin
                  if (x_mod_is_reg_ff) begin
                     c_idx   = x_rm_field_ff;
                     c_val   = x_immediate_ff & size_mask(x_size_ff);
                     c_write = 1'b1;
                  end else begin
                     rsp_kind_in = KIND_WRITE;
                     rsp_addr_in = 32'(x_address_ff[ADDR_WIDTH-1:0]);
                     rsp_data_in = x_immediate_ff & size_mask(x_size_ff);
                     rsp_size_in = x_size_ff;
                  end
               end
               OP_MOVSB: begin
                  if (!(x_rep_ff && rf_ff[REG_ECX] == '0)) begin
                     if (x_rep_ff) begin
                        rf_in[REG_ECX] = ecx_dec;
                        rsp_wreg_in    = {1'b0, REG_ECX};
                        rsp_wval_in    = ecx_dec;
                     end
                     rsp_kind_in  = KIND_READ;
                     rsp_addr_in  = 32'(rf_ff[REG_ESI][ADDR_WIDTH-1:0]);
                     pend_kind_in = PEND_MOVSB;
                     pend_dest_in = {1'b0, x_rep_ff, x_df_ff};
                     pend_size_in = SZ_BYTE;
                  end
               end
               default: rsp_kind_in = KIND_ERROR;
            endcase
         end

         c_reg = view_reg(c_size, c_idx);
         c_new = view_put(c_size, c_idx, x_dst_ff, c_val);
         if (c_write) begin
            rf_in[c_reg] = c_new;
            rsp_wreg_in  = {1'b0, c_reg};
            rsp_wval_in  = c_new;
         end
      end else begin
         c_reg = view_reg(c_size, c_idx);
         c_new = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            rf_ff[i] <= '0;
         end
         pend_kind_ff <= PEND_NONE;
         pend_dest_ff <= '0;
         pend_size_ff <= SZ_BYTE;
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_REGS; i++) begin
            rf_ff[i] <= rf_in[i];
         end
         pend_kind_ff <= pend_kind_in;
         pend_dest_ff <= pend_dest_in;
         pend_size_ff <= pend_size_in;
         if (req_ready) begin
            x_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_op_ff         <= req_op;
         x_size_ff       <= req_size;
         x_mod_is_reg_ff <= req_mod_is_reg;
         x_reg_field_ff  <= req_reg_field;
         x_rm_field_ff   <= req_rm_field;
         x_address_ff    <= req_address;
         x_immediate_ff  <= req_immediate;
         x_rep_ff        <= req_rep_prefix;
         x_df_ff         <= req_direction_flag;
         x_load_data_ff  <= req_load_data;
         x_src_ff        <= x_src_in;
         x_dst_ff        <= x_dst_in;
      end
      if (advance) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_addr_ff <= rsp_addr_in;
         rsp_data_ff <= rsp_data_in;
         rsp_size_ff <= rsp_size_in;
         rsp_wreg_ff <= rsp_wreg_in;
         rsp_wval_ff <= rsp_wval_in;
         rsp_rpt_ff  <= rsp_rpt_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_mem_address   = rsp_addr_ff;
   assign rsp_mem_data      = rsp_data_ff;
   assign rsp_mem_size      = rsp_size_ff;
   assign rsp_written_reg   = rsp_wreg_ff;
   assign rsp_written_value = rsp_wval_ff;
   assign rsp_repeat_res    = rsp_rpt_ff;

endmodule

`default_nettype wire
